// File: rtl/core/kvt_pkg.sv
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared types and constants for the key/value table core.
// ----------------------------------------------------------------------------
package kvt_pkg;

  localparam int KVT_ENTRIES = 64;
  localparam int KVT_DATA_W  = 32;

  localparam logic [KVT_DATA_W-1:0] KVT_NOT_FOUND = '1;

  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_GET    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_kind_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SCAN   = 2'd1,
    S_FINISH = 2'd2
  } state_t;

  typedef struct packed {
    logic                  active;
    logic [KVT_DATA_W-1:0] key;
    logic                  hit;
    logic [KVT_DATA_W-1:0] hit_val;
    logic                  free_seen;
  } token_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [KVT_DATA_W-1:0] key;
    logic [KVT_DATA_W-1:0] val;
  } cmd_t;

endpackage

// File: rtl/core/kvt_cell.sv
// ----------------------------------------------------------------------------
// kvt_cell
// One table entry: key, value and valid bit, with a registered search stage.
// ----------------------------------------------------------------------------
module kvt_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  kvt_pkg::token_t tok_in,
  input  kvt_pkg::cmd_t   cmd,
  output kvt_pkg::token_t tok_out,
  output logic           valid
);
  import kvt_pkg::*;

  logic [KVT_DATA_W-1:0] key_r;
  logic [KVT_DATA_W-1:0] val_r;
  logic                  valid_r;
  logic                  sel_hit_r;
  logic                  sel_free_r;
  logic                  active_r;
  token_t                tok_r;
  logic                  hit_here;
  logic                  free_here;

  assign hit_here  = valid_r && (key_r == tok_in.key) && !tok_in.hit;
  assign free_here = !valid_r && !tok_in.free_seen;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      sel_hit_r  <= 1'b0;
      sel_free_r <= 1'b0;
    end else begin
      active_r <= tok_in.active;
      if (tok_in.active) begin
        sel_hit_r  <= hit_here;
        sel_free_r <= free_here;
      end
    end
  end

  always_ff @(posedge clk) begin
    tok_r.active    <= 1'b0;
    tok_r.key       <= tok_in.key;
    tok_r.hit       <= tok_in.hit || hit_here;
    tok_r.hit_val   <= hit_here ? val_r : tok_in.hit_val;
    tok_r.free_seen <= tok_in.free_seen || !valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      unique case (cmd.kind)
        CMD_INSERT: if (sel_free_r) valid_r <= 1'b1;
        CMD_REMOVE: if (sel_hit_r) valid_r <= 1'b0;
        default:    valid_r <= valid_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((cmd.kind == CMD_INSERT) && sel_free_r) begin
      key_r <= cmd.key;
      val_r <= cmd.val;
    end else if ((cmd.kind == CMD_UPDATE) && sel_hit_r) begin
      val_r <= cmd.val;
    end
  end

  always_comb begin
    tok_out        = tok_r;
    tok_out.active = active_r;
  end

  assign valid = valid_r;

endmodule

// File: rtl/core/kvt_ctrl.sv
// ----------------------------------------------------------------------------
// kvt_ctrl
// Request sequencer: launches the search, decides the result and write-back.
// ----------------------------------------------------------------------------
module kvt_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [kvt_pkg::KVT_DATA_W-1:0]     in_key,
  input  logic [kvt_pkg::KVT_DATA_W-1:0]     in_val,
  input  kvt_pkg::op_t                       in_op,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [kvt_pkg::KVT_DATA_W-1:0]     out_val,
  output kvt_pkg::status_t                   out_status,
  output kvt_pkg::token_t                    tok_head,
  input  kvt_pkg::token_t                    tok_tail,
  output kvt_pkg::cmd_t                      cmd
);
  import kvt_pkg::*;

  state_t                state_r, state_nxt;
  op_t                   op_r;
  logic [KVT_DATA_W-1:0] key_r;
  logic [KVT_DATA_W-1:0] val_r;
  logic                  start_r;
  logic                  hit_r;
  logic [KVT_DATA_W-1:0] hit_val_r;
  logic                  free_r;
  logic                  out_valid_r;
  logic [KVT_DATA_W-1:0] out_val_r;
  status_t               out_status_r;
  cmd_t                  cmd_r;
  logic                  accept;
  logic                  out_free;
  logic                  finish;
  status_t               status_nxt;
  logic [KVT_DATA_W-1:0] rv_nxt;
  cmd_kind_t             kind_nxt;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign finish    = (state_r == S_FINISH) && out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_tvalid) state_nxt = S_SCAN;
      S_SCAN:   if (tok_tail.active) state_nxt = S_FINISH;
      S_FINISH: if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    status_nxt = STAT_OK;
    rv_nxt     = '0;
    kind_nxt   = CMD_NONE;
    unique case (op_r)
      OP_PUT: begin
        if (hit_r) begin
          kind_nxt = CMD_UPDATE;
        end else if (free_r) begin
          kind_nxt = CMD_INSERT;
        end else begin
          status_nxt = STAT_FULL;
        end
      end
      OP_GET: begin
        if (hit_r) begin
          rv_nxt = hit_val_r;
        end else begin
          status_nxt = STAT_MISS;
          rv_nxt     = KVT_NOT_FOUND;
        end
      end
      OP_REMOVE: begin
        if (hit_r) begin
          kind_nxt = CMD_REMOVE;
        end else begin
          status_nxt = STAT_MISS;
        end
      end
      default: begin
        kind_nxt = CMD_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
      cmd_r.kind  <= CMD_NONE;
    end else begin
      state_r <= state_nxt;
      start_r <= accept;
      if (finish) begin
        out_valid_r <= 1'b1;
        cmd_r.kind  <= kind_nxt;
        cmd_r.key   <= key_r;
        cmd_r.val   <= val_r;
      end else begin
        cmd_r.kind <= CMD_NONE;
        if (out_tready) out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_op;
      key_r <= in_key;
      val_r <= in_val;
    end
    if ((state_r == S_SCAN) && tok_tail.active) begin
      hit_r     <= tok_tail.hit;
      hit_val_r <= tok_tail.hit_val;
      free_r    <= tok_tail.free_seen;
    end
    if (finish) begin
      out_val_r    <= rv_nxt;
      out_status_r <= status_nxt;
    end
  end

  always_comb begin
    tok_head.active    = start_r;
    tok_head.key       = key_r;
    tok_head.hit       = 1'b0;
    tok_head.hit_val   = '0;
    tok_head.free_seen = 1'b0;
  end

  assign out_tvalid = out_valid_r;
  assign out_val    = out_val_r;
  assign out_status = out_status_r;
  assign cmd        = cmd_r;

endmodule

// File: rtl/core/key_value_table_core.sv
// ----------------------------------------------------------------------------
// key_value_table_core
// Associative table of signed 32-bit keys and values, searched by a cell row.
// ----------------------------------------------------------------------------
// Each input transaction carries an opcode in in_tuser (put, get or remove)
// and a key and value in in_tdata. Each request yields exactly one output
// transaction: a status in out_tuser and a read value in out_tdata.
// A request travels down a row of ENTRIES cells, one cell per cycle, while
// every cell compares its key and notes whether it is the lowest free entry.
// At the end of the row the sequencer forms the result; for a put or remove
// that takes effect it broadcasts one write-back to the selected cell.
// The sequencer registers an accepted request, sends it down the row, latches
// the search result and then fills the output register; it takes no new
// request until it has placed the previous result and returned to idle.
// Reset clears all valid bits at once, so the table starts empty and ready.
// The result sits in an output register; if the receiver stalls, the next
// request is still accepted and searched, and it waits at the end of the row
// until the output register is free.
// ----------------------------------------------------------------------------
module key_value_table_core #(
  parameter int ENTRIES = kvt_pkg::KVT_ENTRIES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] lookup_key, [63:32] write_value
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] read_value
  output logic [1:0]  out_tuser   // [1:0] status
);
  import kvt_pkg::*;

  token_t            tok [ENTRIES+1];
  logic [ENTRIES-1:0] valid_vec;
  cmd_t              cmd;
  status_t           status;

  kvt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_key     (in_tdata[31:0]),
    .in_val     (in_tdata[63:32]),
    .in_op      (op_t'(in_tuser)),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_val    (out_tdata),
    .out_status (status),
    .tok_head   (tok[0]),
    .tok_tail   (tok[ENTRIES]),
    .cmd        (cmd)
  );

  assign out_tuser = status;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    kvt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_in  (tok[i]),
      .cmd     (cmd),
      .tok_out (tok[i+1]),
      .valid   (valid_vec[i])
    );
  end

  a_tail_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tok[ENTRIES].active |-> !in_tready)
    else $error("search result arrived while the sequencer was idle");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("sequencer still ready after taking a request");

  a_full_means_all_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (tok[ENTRIES].active && !tok[ENTRIES].free_seen) |-> (&valid_vec))
    else $error("search reported no free entry while one is free");

endmodule

// File: test/key_value_table_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_table_core_tb
// Self-checking bench for the key/value table core. Requests go in as stream
// transactions and every result is compared with a local copy of the table
// that is kept in step with each accepted request. The run starts with
// directed requests on an empty and a sparse table. Random traffic then fills
// the table to capacity, empties it again and mixes puts, gets and removes
// over stored, pooled and random keys. Both sides of the core stall at random.
// ----------------------------------------------------------------------------
module key_value_table_core_tb;
  import kvt_pkg::*;

  localparam int ENTRIES    = KVT_ENTRIES;
  localparam int IDLE_LIMIT = 2000;

  typedef struct {
    status_t     status;
    logic [31:0] read_value;
  } kv_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;  // [31:0] lookup_key, [63:32] write_value
  logic [1:0]  in_tuser   = OP_NOP;  // [1:0] opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;  // [31:0] read_value
  logic [1:0]  out_tuser;  // [1:0] status

  logic [31:0] table_keys   [ENTRIES];
  logic [31:0] table_values [ENTRIES];
  logic        table_used   [ENTRIES] = '{default: 1'b0};
  kv_result_t  expected_results [$];
  logic [31:0] key_pool [8];

  bit calm = 1'b0;
  int errors      = 0;
  int idle_cycles = 0;
  int stall_left  = 0;
  int n_put       = 0;
  int n_get       = 0;
  int n_remove    = 0;
  int n_ignored   = 0;
  int n_full      = 0;
  int n_miss      = 0;

  key_value_table_core #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #4 clk = ~clk;

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 11))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  function automatic int find_entry(logic [31:0] k);
    for (int i = 0; i < ENTRIES; i++) begin
      if (table_used[i] && table_keys[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic int find_free_entry();
    for (int i = 0; i < ENTRIES; i++) begin
      if (!table_used[i]) return i;
    end
    return -1;
  endfunction

  function automatic int stored_count();
    int n;
    n = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (table_used[i]) n++;
    end
    return n;
  endfunction

  function automatic logic [31:0] pick_stored_key();
    int start;
    start = $urandom_range(0, ENTRIES - 1);
    for (int i = 0; i < ENTRIES; i++) begin
      if (table_used[(start + i) % ENTRIES]) return table_keys[(start + i) % ENTRIES];
    end
    return random_word();
  endfunction

  function automatic kv_result_t apply_request(op_t op, logic [31:0] k, logic [31:0] v);
    kv_result_t r;
    int slot;
    r.status     = STAT_OK;
    r.read_value = '0;
    slot = find_entry(k);
    case (op)
      OP_PUT: begin
        if (slot < 0) begin
          slot = find_free_entry();
          if (slot >= 0) begin
            table_keys[slot] = k;
            table_used[slot] = 1'b1;
          end
        end
        if (slot < 0) r.status = STAT_FULL;
        else table_values[slot] = v;
      end
      OP_GET: begin
        if (slot < 0) begin
          r.status     = STAT_MISS;
          r.read_value = KVT_NOT_FOUND;
        end else begin
          r.read_value = table_values[slot];
        end
      end
      OP_REMOVE: begin
        if (slot < 0) r.status = STAT_MISS;
        else table_used[slot] = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("tb: mismatch at %0t, %s: got %h, expected %h", $time, what, got, want);
  endtask

  task automatic send_request(op_t op, logic [31:0] k, logic [31:0] v);
    kv_result_t want;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {v, k};
    do @(posedge clk); while (!in_tready);
    want = apply_request(op, k, v);
    expected_results.push_back(want);
    case (op)
      OP_PUT:    n_put++;
      OP_GET:    n_get++;
      OP_REMOVE: n_remove++;
      default:   n_ignored++;
    endcase
    if (want.status == STAT_FULL) n_full++;
    if (want.status == STAT_MISS) n_miss++;
  endtask

  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic test_empty_table();
    send_request(OP_GET, 32'h0000_0000, $urandom());
    send_request(OP_REMOVE, 32'hffff_ffff, 32'h0000_0000);
    send_request(OP_NOP, 32'h8000_0000, 32'h7fff_ffff);
    send_request(OP_GET, 32'h7fff_ffff, 32'hffff_ffff);
  endtask

  task automatic test_extreme_pairs();
    send_request(OP_PUT, 32'h8000_0000, 32'h7fff_ffff);
    send_request(OP_PUT, 32'h7fff_ffff, 32'h8000_0000);
    send_request(OP_PUT, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_PUT, 32'hffff_ffff, 32'hffff_ffff);
    send_request(OP_GET, 32'h8000_0000, 32'h0000_0000);
    send_request(OP_GET, 32'h7fff_ffff, 32'hffff_ffff);
    send_request(OP_GET, 32'h0000_0000, 32'h5555_5555);
    send_request(OP_GET, 32'hffff_ffff, 32'haaaa_aaaa);
  endtask

  task automatic test_overwrite_and_remove();
    send_request(OP_PUT, 32'h0000_0000, 32'h1234_5678);
    send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_REMOVE, 32'h0000_0000, 32'hffff_ffff);
    send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_REMOVE, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_NOP, 32'h7fff_ffff, 32'h0000_0000);
    send_request(OP_GET, 32'h7fff_ffff, 32'h0000_0000);
    send_request(OP_PUT, 32'h0000_0000, 32'h8765_4321);
    send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
  endtask

  task automatic test_mixed_traffic(int count);
    op_t         op;
    logic [31:0] k;
    int          pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 38)      op = OP_PUT;
      else if (pick < 72) op = OP_GET;
      else if (pick < 94) op = OP_REMOVE;
      else                op = OP_NOP;
      pick = $urandom_range(0, 9);
      if (pick < 5)      k = pick_stored_key();
      else if (pick < 8) k = key_pool[$urandom_range(0, 7)];
      else               k = random_word();
      send_request(op, k, random_word());
    end
  endtask

  task automatic test_fill_to_full();
    wait_all_results();
    while (stored_count() < ENTRIES) send_request(OP_PUT, random_word(), random_word());
    repeat (3) send_request(OP_PUT, $urandom(), random_word());
    send_request(OP_PUT, pick_stored_key(), random_word());
    repeat (6) send_request(OP_GET, pick_stored_key(), random_word());
    repeat (2) send_request(OP_GET, $urandom(), random_word());
    repeat (3) send_request(OP_REMOVE, pick_stored_key(), random_word());
    repeat (4) send_request(OP_PUT, $urandom(), random_word());
    repeat (4) send_request(OP_GET, pick_stored_key(), random_word());
  endtask

  task automatic test_empty_out();
    while (stored_count() > 0) begin
      send_request(OP_REMOVE, pick_stored_key(), random_word());
      if ($urandom_range(0, 3) == 0) send_request(OP_GET, pick_stored_key(), random_word());
    end
    repeat (4) send_request(OP_GET, key_pool[$urandom_range(0, 7)], random_word());
  endtask

  always @(posedge clk) begin
    if (calm) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    kv_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result without a request", out_tdata, 32'h0);
      end else begin
        want = expected_results.pop_front();
        if (out_tuser !== want.status) report_mismatch("status", 32'(out_tuser),
                                                       32'(want.status));
        if (out_tdata !== want.read_value) report_mismatch("read value", out_tdata,
                                                           want.read_value);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: no transaction for %0d cycles, giving up", IDLE_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < 8; i++) key_pool[i] = random_word();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_extreme_pairs();
    test_overwrite_and_remove();
    test_mixed_traffic(200);
    test_fill_to_full();
    test_empty_out();
    calm = 1'b1;
    test_mixed_traffic(80);

    wait_all_results();
    repeat (ENTRIES + 8) @(posedge clk);
    if (expected_results.size() != 0) begin
      report_mismatch("results never delivered", expected_results.size(), 32'h0);
    end

    $display("tb: covered %0d puts, %0d gets, %0d removes and %0d ignored requests",
             n_put, n_get, n_remove, n_ignored);
    $display("tb: %0d table-full and %0d not-found results, with stalls on both sides",
             n_full, n_miss);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/kvt_pkg.sv
rtl/core/kvt_cell.sv
rtl/core/kvt_ctrl.sv
rtl/core/key_value_table_core.sv
test/key_value_table_core_tb.sv
